// ===== rtl/gpqvr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the GARCH(p,q) variance recursion block.
package gpqvr_pkg;

    // Field widths
    localparam int MODE_W    = 2;
    localparam int VAL_W     = 32;
    localparam int COEF_W    = 17;
    localparam int IDX_W     = 4;
    localparam int ORDER_W   = 3;
    localparam int CFG_IDX_W = 2;
    localparam int FRAC_W    = 16;
    localparam int PROD_W    = COEF_W + VAL_W;
    localparam int ACC_W     = 64;

    // Input item modes
    localparam logic [MODE_W-1:0] MODE_START  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ARCH_ORDER  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GARCH_ORDER = 2'd1;

    // Reset value of both orders
    localparam logic [ORDER_W-1:0] ORDER_RESET = 3'd1;

    // 1.0 in Q16.16: multiplies the constant term up to Q17.32
    localparam logic [VAL_W-1:0] ONE_Q16 = 32'h0001_0000;

    // Half an LSB of Q16.16 expressed in Q17.32
    localparam logic [ACC_W-1:0] ROUND_HALF = 64'h0000_0000_0000_8000;

    // Sequencer commands to the multiply-accumulate unit
    typedef struct packed {
        logic clear;
        logic issue;
    } mac_ctrl_t;

    // Sequencer status to the top level
    typedef struct packed {
        logic busy;
        logic finish;
    } seq_stat_t;

endpackage

// ===== rtl/gpqvr_ifs.sv =====
`timescale 1ns / 1ps
// Channel interfaces: sample input, variance result and configuration write.
interface gpqvr_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [31:0] residual_sq;
    logic [31:0] seed_variance;
    logic [3:0]  coef_index;
    logic [16:0] coef_value;

    modport source (
        output valid, mode, residual_sq, seed_variance, coef_index, coef_value,
        input  ready
    );
    modport sink (
        input  valid, mode, residual_sq, seed_variance, coef_index, coef_value,
        output ready
    );
endinterface

interface gpqvr_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] variance;
    logic        saturated;

    modport source (
        output valid, variance, saturated,
        input  ready
    );
    modport sink (
        input  valid, variance, saturated,
        output ready
    );
endinterface

interface gpqvr_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [2:0]  data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// ===== rtl/gpqvr_mac.sv =====
`timescale 1ns / 1ps
// Shared multiply-accumulate unit with round-half-up and saturation to Q16.16.
module gpqvr_mac (
    input  logic                       clk,
    input  logic                       rst_n,
    input  gpqvr_pkg::mac_ctrl_t       ctrl,
    input  logic [gpqvr_pkg::COEF_W-1:0] coef,
    input  logic [gpqvr_pkg::VAL_W-1:0]  val,
    output logic [gpqvr_pkg::VAL_W-1:0]  variance,
    output logic                       saturated
);
    import gpqvr_pkg::*;

    logic [PROD_W-1:0] prod_reg;
    logic              prod_valid_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [ACC_W-1:0]  acc_next;
    logic [ACC_W-1:0]  rounded_sum;
    logic [ACC_W-FRAC_W-1:0] rounded;

    // Multiply stage: one coefficient-value product a cycle
    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(coef) * PROD_W'(val);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= ctrl.issue;
        end
    end

    // Accumulate stage: exact sum of all terms in Q32.32
    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.clear)
        begin
            acc_next = '0;
        end
        else if (prod_valid_reg)
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    // Round half up to Q16.16, clamp anything above 32 bits
    assign rounded_sum = acc_reg + ROUND_HALF;
    assign rounded     = rounded_sum[ACC_W-1:FRAC_W];
    assign saturated   = |rounded[ACC_W-FRAC_W-1:VAL_W];
    assign variance    = saturated ? '1 : rounded[VAL_W-1:0];

endmodule

// ===== rtl/gpqvr_seq.sv =====
`timescale 1ns / 1ps
// Sequencer: steps the shared unit through the constant, arch and garch terms.
module gpqvr_seq #(
    parameter int MAX_P = 4,
    parameter int MAX_Q = 4
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic [$clog2(MAX_P+1)-1:0]             arch_taps,
    input  logic [$clog2(MAX_Q+1)-1:0]             garch_taps,
    input  logic                                   out_free,
    output logic [$clog2(1+MAX_P+MAX_Q)-1:0]       term,
    output logic [$clog2(MAX_P+1)-1:0]             run_arch_taps,
    output gpqvr_pkg::mac_ctrl_t                   mac_ctrl,
    output gpqvr_pkg::seq_stat_t                   stat
);
    import gpqvr_pkg::*;

    localparam int PW = $clog2(MAX_P + 1);
    localparam int KW = $clog2(1 + MAX_P + MAX_Q);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_RUN   = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DONE  = 4'b1000
    } seq_state_t;

    seq_state_t       state_reg;
    seq_state_t       state_next;
    logic [KW-1:0]    term_reg;
    logic [KW-1:0]    term_next;
    logic [KW-1:0]    last_reg;
    logic [KW-1:0]    last_next;
    logic [PW-1:0]    p_reg;
    logic [PW-1:0]    p_next;

    // Next-state logic
    always_comb
    begin
        state_next    = state_reg;
        term_next     = term_reg;
        last_next     = last_reg;
        p_next        = p_reg;
        mac_ctrl      = '0;
        stat.busy     = (state_reg != S_IDLE);
        stat.finish   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    // Latch the orders for this sample and clear the sum
                    term_next      = '0;
                    last_next      = KW'(arch_taps) + KW'(garch_taps);
                    p_next         = arch_taps;
                    mac_ctrl.clear = 1'b1;
                    state_next     = S_RUN;
                end
            end
            S_RUN:
            begin
                mac_ctrl.issue = 1'b1;
                if (term_reg == last_reg)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    term_next = term_reg + KW'(1);
                end
            end
            S_DRAIN:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // Hold the result until the output register is free
                if (out_free)
                begin
                    stat.finish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            term_reg  <= '0;
            last_reg  <= '0;
            p_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            term_reg  <= term_next;
            last_reg  <= last_next;
            p_reg     <= p_next;
        end
    end

    assign term          = term_reg;
    assign run_arch_taps = p_reg;

endmodule

// ===== rtl/garch_pq_variance_recursion.sv =====
`timescale 1ns / 1ps
// Top level of the GARCH(p,q) conditional variance recursion.
//
// Each residual beat (mode 1) yields one variance beat: c0 plus p arch taps on the
// newest squared residuals plus q garch taps on the newest variances, summed exactly,
// rounded half up to Q16.16 and clamped with the saturated flag. A residual beat keeps
// the input busy from acceptance until the sequencer is back in idle: one term per cycle
// goes through the single shared 17 x 32 multiplier, then a drain state lets the last
// product reach the accumulator and a done state rounds the sum and hands it over.
// Start (mode 0), coefficient load (mode 2) and unused mode 3 beats leave the input ready.
// The result sits in an output register, so the next beat is taken while it waits;
// a residual beat stalls in its done state only while an earlier result is still
// untaken. Configuration writes are taken every cycle and apply from the next sample.
module garch_pq_variance_recursion #(
    parameter int MAX_P = 4,
    parameter int MAX_Q = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    gpqvr_in_if.sink    sample,
    gpqvr_out_if.source result,
    gpqvr_cfg_if.sink   cfg
);
    import gpqvr_pkg::*;

    localparam int CD = 1 + MAX_P + MAX_Q;
    localparam int KW = $clog2(CD);
    localparam int PW = $clog2(MAX_P + 1);
    localparam int QW = $clog2(MAX_Q + 1);

    logic [ORDER_W-1:0] arch_order_reg;
    logic [ORDER_W-1:0] garch_order_reg;
    logic [VAL_W-1:0]   rhist_reg [MAX_P];
    logic [VAL_W-1:0]   vhist_reg [MAX_Q];
    logic [COEF_W-1:0]  coef_reg  [CD];

    logic [PW-1:0]      p_eff;
    logic [QW-1:0]      q_eff;
    logic [PW-1:0]      p_run;
    logic [KW-1:0]      term;
    logic               accept;
    logic               start_sample;
    logic               out_free;
    mac_ctrl_t          mac_ctrl;
    seq_stat_t          stat;
    logic [COEF_W-1:0]  coef_sel;
    logic [VAL_W-1:0]   val_sel;
    logic [VAL_W-1:0]   mac_variance;
    logic               mac_saturated;

    logic               out_valid_reg;
    logic [VAL_W-1:0]   variance_reg;
    logic               saturated_reg;

    assign accept       = sample.valid & sample.ready;
    assign start_sample = accept && (sample.mode == MODE_SAMPLE);
    assign sample.ready = ~stat.busy;
    assign cfg.ready    = 1'b1;
    assign out_free     = ~out_valid_reg | result.ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arch_order_reg  <= ORDER_RESET;
            garch_order_reg <= ORDER_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_ARCH_ORDER:  arch_order_reg  <= cfg.data;
                REG_GARCH_ORDER: garch_order_reg <= cfg.data;
                default:         ;
            endcase
        end
    end

    // Clamp the orders to the tap counts that are built
    always_comb
    begin
        if (int'(arch_order_reg) > MAX_P)
        begin
            p_eff = PW'(MAX_P);
        end
        else
        begin
            p_eff = PW'(arch_order_reg);
        end
        if (int'(garch_order_reg) > MAX_Q)
        begin
            q_eff = QW'(MAX_Q);
        end
        else
        begin
            q_eff = QW'(garch_order_reg);
        end
    end

    // Residual history: clear on start, shift in on a sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_P; i++)
            begin
                rhist_reg[i] <= '0;
            end
        end
        else if (accept && (sample.mode == MODE_START))
        begin
            for (int i = 0; i < MAX_P; i++)
            begin
                rhist_reg[i] <= '0;
            end
        end
        else if (start_sample)
        begin
            for (int i = 1; i < MAX_P; i++)
            begin
                rhist_reg[i] <= rhist_reg[i-1];
            end
            rhist_reg[0] <= sample.residual_sq;
        end
    end

    // Variance history: clear and seed on start, push each new result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_Q; i++)
            begin
                vhist_reg[i] <= '0;
            end
        end
        else if (accept && (sample.mode == MODE_START))
        begin
            for (int i = 1; i < MAX_Q; i++)
            begin
                vhist_reg[i] <= '0;
            end
            vhist_reg[0] <= sample.seed_variance;
        end
        else if (stat.finish)
        begin
            for (int i = 1; i < MAX_Q; i++)
            begin
                vhist_reg[i] <= vhist_reg[i-1];
            end
            vhist_reg[0] <= mac_variance;
        end
    end

    // Coefficient table: write one slot per load beat, drop slots past the end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CD; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else if (accept && (sample.mode == MODE_LOAD))
        begin
            for (int i = 0; i < CD; i++)
            begin
                if (int'(sample.coef_index) == i)
                begin
                    coef_reg[i] <= sample.coef_value;
                end
            end
        end
    end

    // Operand select for the current term
    assign coef_sel = coef_reg[term];

    always_comb
    begin
        val_sel = '0;
        if (term == '0)
        begin
            val_sel = ONE_Q16;
        end
        else if (term <= KW'(p_run))
        begin
            for (int i = 0; i < MAX_P; i++)
            begin
                if (term == KW'(i + 1))
                begin
                    val_sel = rhist_reg[i];
                end
            end
        end
        else
        begin
            for (int i = 0; i < MAX_Q; i++)
            begin
                if (term == KW'(p_run) + KW'(i + 1))
                begin
                    val_sel = vhist_reg[i];
                end
            end
        end
    end

    gpqvr_seq #(
        .MAX_P (MAX_P),
        .MAX_Q (MAX_Q)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start_sample),
        .arch_taps     (p_eff),
        .garch_taps    (q_eff),
        .out_free      (out_free),
        .term          (term),
        .run_arch_taps (p_run),
        .mac_ctrl      (mac_ctrl),
        .stat          (stat)
    );

    gpqvr_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (mac_ctrl),
        .coef      (coef_sel),
        .val       (val_sel),
        .variance  (mac_variance),
        .saturated (mac_saturated)
    );

    // Output register: load on finish, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stat.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stat.finish)
        begin
            variance_reg  <= mac_variance;
            saturated_reg <= mac_saturated;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.variance  = variance_reg;
    assign result.saturated = saturated_reg;

endmodule

// ===== dv/tb_garch_pq_variance_recursion.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the GARCH(p,q) conditional variance recursion block.
module tb_garch_pq_variance_recursion;
    import gpqvr_pkg::*;

    localparam int MAX_P        = 4;
    localparam int MAX_Q        = 4;
    localparam int COEF_DEPTH   = 1 + MAX_P + MAX_Q;
    localparam int ITEM_TARGET  = 900;
    localparam int SETTLE_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 500000;

    // Mode 3 has no meaning in the block and must be ignored
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [VAL_W-1:0]  residual_sq;
        logic [VAL_W-1:0]  seed_variance;
        logic [IDX_W-1:0]  coef_index;
        logic [COEF_W-1:0] coef_value;
    } sample_item_t;

    typedef struct packed {
        logic [VAL_W-1:0] variance;
        logic             saturated;
    } variance_beat_t;

    // Tracks the recursion state and holds the variances still owed by the block
    class garch_variance_tracker;
        logic [ORDER_W-1:0] arch_order;
        logic [ORDER_W-1:0] garch_order;
        logic [VAL_W-1:0]   residual_hist[MAX_P];
        logic [VAL_W-1:0]   variance_hist[MAX_Q];
        logic [COEF_W-1:0]  coef_table[COEF_DEPTH];
        variance_beat_t     awaited[$];
        int unsigned samples, loads, starts, ignored, checked, saturations, errors;

        function new();
            arch_order  = ORDER_RESET;
            garch_order = ORDER_RESET;
            foreach (residual_hist[i]) residual_hist[i] = '0;
            foreach (variance_hist[i]) variance_hist[i] = '0;
            foreach (coef_table[i]) coef_table[i] = '0;
        endfunction

        function void set_order(logic [CFG_IDX_W-1:0] idx, logic [ORDER_W-1:0] val);
            if (idx == REG_ARCH_ORDER)
                arch_order = val;
            else if (idx == REG_GARCH_ORDER)
                garch_order = val;
        endfunction

        function int unsigned pending();
            return awaited.size();
        endfunction

        function int unsigned effective();
            return samples + loads + starts;
        endfunction

        // Apply one accepted beat and queue the variance it produces, if any
        function void note_item(sample_item_t it);
            logic [ACC_W-1:0] acc;
            logic [ACC_W-1:0] rounded;
            int unsigned      p;
            int unsigned      q;
            variance_beat_t   beat;

            case (it.mode)
                MODE_START:
                begin
                    foreach (residual_hist[i]) residual_hist[i] = '0;
                    foreach (variance_hist[i]) variance_hist[i] = '0;
                    variance_hist[0] = it.seed_variance;
                    starts++;
                end
                MODE_LOAD:
                begin
                    if (int'(it.coef_index) < COEF_DEPTH)
                    begin
                        coef_table[it.coef_index] = it.coef_value;
                        loads++;
                    end
                    else
                        ignored++;
                end
                MODE_SAMPLE:
                begin
                    for (int j = MAX_P - 1; j > 0; j--)
                        residual_hist[j] = residual_hist[j-1];
                    residual_hist[0] = it.residual_sq;

                    p = (int'(arch_order) > MAX_P) ? MAX_P : int'(arch_order);
                    q = (int'(garch_order) > MAX_Q) ? MAX_Q : int'(garch_order);

                    // Sum every term exactly in Q32.32
                    acc = ACC_W'(coef_table[0]) << FRAC_W;
                    for (int j = 1; j <= p; j++)
                        acc += ACC_W'(coef_table[j]) * ACC_W'(residual_hist[j-1]);
                    for (int j = 1; j <= q; j++)
                        acc += ACC_W'(coef_table[p+j]) * ACC_W'(variance_hist[j-1]);

                    // Round half up to Q16.16, then clamp
                    rounded = (acc + ROUND_HALF) >> FRAC_W;
                    if (rounded > 64'h0000_0000_FFFF_FFFF)
                    begin
                        beat.variance  = '1;
                        beat.saturated = 1'b1;
                        saturations++;
                    end
                    else
                    begin
                        beat.variance  = rounded[VAL_W-1:0];
                        beat.saturated = 1'b0;
                    end

                    for (int j = MAX_Q - 1; j > 0; j--)
                        variance_hist[j] = variance_hist[j-1];
                    variance_hist[0] = beat.variance;
                    awaited.push_back(beat);
                    samples++;
                end
                default:
                    ignored++;
            endcase
        endfunction

        // Compare one result beat with the oldest owed variance
        function void check_variance(logic [VAL_W-1:0] v, logic s);
            variance_beat_t want;

            if (awaited.size() == 0)
            begin
                errors++;
                $display("%0t: variance beat with none owed, expected none actual %h sat %b",
                         $time, v, s);
                return;
            end
            want = awaited.pop_front();
            checked++;
            if (v !== want.variance)
            begin
                errors++;
                $display("%0t: variance mismatch, expected %h actual %h",
                         $time, want.variance, v);
            end
            if (s !== want.saturated)
            begin
                errors++;
                $display("%0t: saturated mismatch, expected %b actual %b",
                         $time, want.saturated, s);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    gpqvr_in_if  sample_ch();
    gpqvr_out_if result_ch();
    gpqvr_cfg_if cfg_ch();

    garch_variance_tracker vtrack = new();

    int unsigned cycles;
    int unsigned burst_left;
    bit          no_idle;
    int unsigned hold_cycles;
    int unsigned holds_done;
    int unsigned pattern_left;
    int unsigned rx_style;
    int unsigned phases_run;

    garch_pq_variance_recursion #(
        .MAX_P(MAX_P),
        .MAX_Q(MAX_Q)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .sample(sample_ch),
        .result(result_ch),
        .cfg   (cfg_ch)
    );

    // Clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Known levels on every input from time zero
    initial
    begin
        rst_n                   = 1'b0;
        sample_ch.valid         = 1'b0;
        sample_ch.mode          = MODE_START;
        sample_ch.residual_sq   = '0;
        sample_ch.seed_variance = '0;
        sample_ch.coef_index    = '0;
        sample_ch.coef_value    = '0;
        result_ch.ready         = 1'b0;
        cfg_ch.valid            = 1'b0;
        cfg_ch.index            = REG_ARCH_ORDER;
        cfg_ch.data             = '0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d variances still owed",
                     $time, cycles, vtrack.pending());
            $display("garch_pq_variance_recursion test failed");
            $finish;
        end
    end

    // Result side: check each beat, stall on a shifting pattern, hold off twice at length
    always @(posedge clk)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                vtrack.check_variance(result_ch.variance, result_ch.saturated);
                if ((vtrack.checked == 200 || vtrack.checked == 650) && hold_cycles == 0)
                begin
                    hold_cycles = 400;
                    holds_done++;
                end
            end
            if (hold_cycles != 0)
            begin
                hold_cycles--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                if (pattern_left == 0)
                begin
                    rx_style     = $urandom_range(0, 3);
                    pattern_left = $urandom_range(30, 200);
                end
                pattern_left--;
                case (rx_style)
                    0:       result_ch.ready <= 1'b1;
                    1:       result_ch.ready <= 1'($urandom_range(0, 1));
                    2:       result_ch.ready <= ($urandom_range(0, 5) == 0);
                    default: result_ch.ready <= ~result_ch.ready;
                endcase
            end
        end
    end

    function automatic sample_item_t make_item(logic [MODE_W-1:0] mode,
                                               logic [VAL_W-1:0] res,
                                               logic [VAL_W-1:0] seed,
                                               logic [IDX_W-1:0] idx,
                                               logic [COEF_W-1:0] val);
        sample_item_t it;

        it.mode          = mode;
        it.residual_sq   = res;
        it.seed_variance = seed;
        it.coef_index    = idx;
        it.coef_value    = val;
        return it;
    endfunction

    // Mostly modest residuals, some full range, a few at the edges
    function automatic logic [VAL_W-1:0] rand_residual();
        int unsigned pick;

        pick = $urandom_range(0, 9);
        if (pick < 6)
            return $urandom_range(0, 32'h0004_0000);
        if (pick < 8)
            return $urandom;
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            2:       return 32'h0000_8000;
            default: return 32'h0000_7FFF;
        endcase
    endfunction

    // Taps kept small so the recursion stays stable, with the odd full-range value
    function automatic logic [COEF_W-1:0] rand_coef(bit is_tap);
        if ($urandom_range(0, 7) == 0)
            return COEF_W'($urandom_range(0, 17'h1FFFF));
        return is_tap ? COEF_W'($urandom_range(0, 17'h5000))
                      : COEF_W'($urandom_range(0, 17'h8000));
    endfunction

    function automatic logic [VAL_W-1:0] rand_seed();
        return $urandom_range(0, 1) ? $urandom_range(0, 32'h0004_0000) : $urandom;
    endfunction

    // Offer one beat, hold it until taken, then pace the burst
    task automatic send_item(input sample_item_t it);
        int unsigned gap;

        sample_ch.valid         <= 1'b1;
        sample_ch.mode          <= it.mode;
        sample_ch.residual_sq   <= it.residual_sq;
        sample_ch.seed_variance <= it.seed_variance;
        sample_ch.coef_index    <= it.coef_index;
        sample_ch.coef_value    <= it.coef_value;
        do @(posedge clk); while (!sample_ch.ready);
        vtrack.note_item(it);

        if (burst_left != 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(1, 20);
            gap = no_idle ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                sample_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Drop valid and wait until every owed variance has come back
    task automatic wait_idle();
        sample_ch.valid <= 1'b0;
        while (vtrack.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_order(input logic [CFG_IDX_W-1:0] idx,
                               input logic [ORDER_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        vtrack.set_order(idx, val);
    endtask

    // One series: new orders, optional fresh coefficients and start, then residuals with noise
    task automatic run_series(input logic [ORDER_W-1:0] arch, input logic [ORDER_W-1:0] garch,
                              input bit fresh);
        int unsigned p;
        int unsigned q;
        int unsigned n;
        int unsigned pick;

        wait_idle();
        write_order(REG_ARCH_ORDER, arch);
        write_order(REG_GARCH_ORDER, garch);
        cfg_ch.valid <= 1'b0;
        no_idle = ($urandom_range(0, 3) == 0);
        p = (int'(arch) > MAX_P) ? MAX_P : int'(arch);
        q = (int'(garch) > MAX_Q) ? MAX_Q : int'(garch);

        if (fresh)
        begin
            for (int i = 0; i <= p + q; i++)
                send_item(make_item(MODE_LOAD, $urandom, $urandom, IDX_W'(i),
                                    rand_coef(i != 0)));
            send_item(make_item(MODE_START, $urandom, rand_seed(),
                                IDX_W'($urandom_range(0, 15)),
                                COEF_W'($urandom_range(0, 17'h1FFFF))));
        end

        n = $urandom_range(40, 70);
        for (int k = 0; k < n; k++)
        begin
            pick = $urandom_range(0, 23);
            case (pick)
                0: send_item(make_item(MODE_UNUSED, $urandom, $urandom,
                                       IDX_W'($urandom_range(0, 15)),
                                       COEF_W'($urandom_range(0, 17'h1FFFF))));
                1: send_item(make_item(MODE_LOAD, $urandom, $urandom,
                                       IDX_W'($urandom_range(COEF_DEPTH, 15)),
                                       COEF_W'($urandom_range(0, 17'h1FFFF))));
                2: send_item(make_item(MODE_LOAD, $urandom, $urandom,
                                       IDX_W'($urandom_range(0, COEF_DEPTH - 1)),
                                       rand_coef(1'b1)));
                3: send_item(make_item(MODE_START, $urandom, rand_seed(),
                                       IDX_W'($urandom_range(0, 15)),
                                       COEF_W'($urandom_range(0, 17'h1FFFF))));
                default: send_item(make_item(MODE_SAMPLE, rand_residual(), $urandom,
                                             IDX_W'($urandom_range(0, 15)),
                                             COEF_W'($urandom_range(0, 17'h1FFFF))));
            endcase
        end
        phases_run++;
    endtask

    // Order settings for the first series: extremes, out-of-range and lopsided mixes
    logic [ORDER_W-1:0] arch_plan[7]  = '{3'd0, 3'd4, 3'd1, 3'd7, 3'd2, 3'd4, 3'd0};
    logic [ORDER_W-1:0] garch_plan[7] = '{3'd0, 3'd4, 3'd1, 3'd7, 3'd3, 3'd0, 3'd4};

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset orders, empty table, rounding edges and saturation
        burst_left = 30;
        send_item(make_item(MODE_SAMPLE, 32'h0, 32'h0, 4'd0, 17'h0));
        send_item(make_item(MODE_LOAD, 32'h0, 32'h0, 4'd0, 17'h1FFFF));
        send_item(make_item(MODE_LOAD, 32'h0, 32'h0, 4'd1, 17'h00001));
        send_item(make_item(MODE_LOAD, 32'h0, 32'h0, 4'd2, 17'h10000));
        send_item(make_item(MODE_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15, 17'h1FFFF));
        send_item(make_item(MODE_LOAD, 32'h0, 32'h0, 4'd9, 17'h1FFFF));
        send_item(make_item(MODE_LOAD, 32'h0, 32'h0, 4'd15, 17'h1FFFF));
        send_item(make_item(MODE_START, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd0, 17'h0));
        send_item(make_item(MODE_SAMPLE, 32'h0000_8000, 32'h0, 4'd0, 17'h0));
        send_item(make_item(MODE_SAMPLE, 32'h0000_0000, 32'h0, 4'd0, 17'h0));
        send_item(make_item(MODE_START, 32'h0, 32'h0, 4'd0, 17'h0));
        send_item(make_item(MODE_LOAD, 32'h0, 32'h0, 4'd0, 17'h0));
        send_item(make_item(MODE_LOAD, 32'h0, 32'h0, 4'd2, 17'h0));
        send_item(make_item(MODE_SAMPLE, 32'h0000_8000, 32'h0, 4'd0, 17'h0));
        send_item(make_item(MODE_SAMPLE, 32'h0000_7FFF, 32'h0, 4'd0, 17'h0));
        send_item(make_item(MODE_LOAD, 32'h0, 32'h0, 4'd1, 17'h1FFFF));
        send_item(make_item(MODE_SAMPLE, 32'hFFFF_FFFF, 32'h0, 4'd0, 17'h0));
        send_item(make_item(MODE_SAMPLE, 32'h0, 32'h0, 4'd0, 17'h0));
        send_item(make_item(MODE_LOAD, 32'h0, 32'h0, 4'd2, 17'h1FFFF));
        send_item(make_item(MODE_START, 32'h0, 32'hFFFF_FFFF, 4'd0, 17'h0));
        send_item(make_item(MODE_SAMPLE, 32'h0, 32'h0, 4'd0, 17'h0));
        send_item(make_item(MODE_SAMPLE, 32'hFFFF_FFFF, 32'h0, 4'd0, 17'h0));

        // Random series across order settings, some continuing without a fresh start
        for (int ph = 0; vtrack.effective() < ITEM_TARGET + 20; ph++)
        begin
            if (ph < 7)
                run_series(arch_plan[ph], garch_plan[ph], 1'b1);
            else
                run_series(ORDER_W'(($urandom_range(0, 9) == 0) ? $urandom_range(5, 7)
                                                                : $urandom_range(0, 4)),
                           ORDER_W'(($urandom_range(0, 9) == 0) ? $urandom_range(5, 7)
                                                                : $urandom_range(0, 4)),
                           $urandom_range(0, 2) != 0);
        end

        wait_idle();
        $display("Ran %0d series: %0d residuals, %0d loads, %0d starts, %0d ignored beats",
                 phases_run, vtrack.samples, vtrack.loads, vtrack.starts, vtrack.ignored);
        $display("Checked %0d variances (%0d saturated) through %0d long result stalls",
                 vtrack.checked, vtrack.saturations, holds_done);
        if (vtrack.errors == 0 && vtrack.pending() == 0)
            $display("garch_pq_variance_recursion test passed");
        else
            $display("garch_pq_variance_recursion test failed");
        $finish;
    end

endmodule
